// ----- hw/rtl/lgfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgfs_pkg
// Shared field widths, action codes and result kinds for the grayscale frame
// shifter and its channel interfaces.
// ----------------------------------------------------------------------------
package lgfs_pkg;

    // field widths of the input and result words
    localparam int ACTION_W      = 3;
    localparam int CHANNEL_W     = 5;
    localparam int VALUE_W       = 12;
    localparam int KIND_W        = 3;
    localparam int WORD_W        = 24;
    localparam int DC_W          = 6;
    localparam int CH_PER_DRIVER = 16;
    localparam int CHAN_CMP_W    = CHANNEL_W + 1;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [CHANNEL_W-1:0] t_channel;
    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [DC_W-1:0]      t_dc;

    // action codes
    localparam t_action ACT_SET        = 3'd0;
    localparam t_action ACT_GET        = 3'd1;
    localparam t_action ACT_SET_ALL    = 3'd2;
    localparam t_action ACT_UPDATE     = 3'd3;
    localparam t_action ACT_DC_ALL     = 3'd4;
    localparam t_action ACT_LATCH_DONE = 3'd5;

    // result kinds
    localparam t_kind KIND_PULSE   = 3'd0;
    localparam t_kind KIND_GRAY    = 3'd1;
    localparam t_kind KIND_DC      = 3'd2;
    localparam t_kind KIND_LATCH   = 3'd3;
    localparam t_kind KIND_READ    = 3'd4;
    localparam t_kind KIND_REFUSED = 3'd5;

endpackage

// ----- hw/rtl/lgfs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgfs_in_if
// Valid/ready channel carrying one command word into the frame shifter.
// ----------------------------------------------------------------------------
interface lgfs_in_if;
    import lgfs_pkg::*;

    logic     valid;
    logic     ready;
    t_action  action;
    t_channel channel;
    t_value   value;

    modport source (output valid, output action, output channel, output value,
                    input ready);
    modport sink   (input valid, input action, input channel, input value,
                    output ready);
endinterface

// ----- hw/rtl/lgfs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgfs_out_if
// Valid/ready channel carrying one result word out of the frame shifter.
// ----------------------------------------------------------------------------
interface lgfs_out_if;
    import lgfs_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_word  word;
    t_value read_value;
    logic   last;

    modport source (output valid, output kind, output word, output read_value,
                    output last, input ready);
    modport sink   (input valid, input kind, input word, input read_value,
                    input last, output ready);
endinterface

// ----- hw/rtl/led_grayscale_frame_shifter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_grayscale_frame_shifter_core
// Grayscale store and word sequencer for a chain of 16-channel LED drivers.
// ----------------------------------------------------------------------------
// get: store read, then reply registered once the result slot is free
// set, latch done: no reply; set all: one store entry written per cycle
// update: one word per cycle from a dual-read store unless the output stalls
// dot correction: one word per cycle unless the output stalls
// one command at a time; result register lets the next command in while full
// sync reset clears control state and per-entry valid bits (store reads zero)
module led_grayscale_frame_shifter_core #(
    parameter int NUM_DRIVERS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lgfs_in_if.sink           i_in,
    lgfs_out_if.source        o_out
);
    import lgfs_pkg::*;

    localparam int CHANNELS = NUM_DRIVERS * CH_PER_DRIVER;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int K_W      = CH_W - 1;
    localparam int PAIRS    = CHANNELS / 2;
    localparam int DC_WORDS = NUM_DRIVERS * 4;

    localparam logic [CH_W-1:0] IDX_LAST = CH_W'(CHANNELS - 1);
    localparam logic [CH_W-1:0] TOP_CH   = CH_W'(CHANNELS - 1);
    localparam logic [K_W-1:0]  K_LAST   = K_W'(PAIRS - 1);
    localparam logic [K_W-1:0]  DC_LAST  = K_W'(DC_WORDS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_GET     = 3'd1;
    localparam logic [2:0] S_SET_ALL = 3'd2;
    localparam logic [2:0] S_PULSE   = 3'd3;
    localparam logic [2:0] S_UPD     = 3'd4;
    localparam logic [2:0] S_DC      = 3'd5;
    localparam logic [2:0] S_LATCH   = 3'd6;
    localparam logic [2:0] S_REFUSE  = 3'd7;

    // store and its valid bits
    t_value r_gray [CHANNELS];
    logic   r_vld  [CHANNELS];

    logic [2:0]      r_state, n_state;
    logic [K_W-1:0]  r_k, n_k;
    logic [CH_W-1:0] r_idx, n_idx;
    t_value          r_fill, n_fill;
    t_dc             r_dc, n_dc;
    logic            r_pending, n_pending;
    logic            r_skip, n_skip;
    logic            r_get_oor, n_get_oor;
    t_value          r_rd_hi, r_rd_lo;

    logic            r_out_valid;
    t_kind           r_out_kind, n_out_kind;
    t_word           r_out_word, n_out_word;
    t_value          r_out_rv, n_out_rv;
    logic            r_out_last, n_out_last;

    logic            w_accept;
    logic            w_slot_free;
    logic            w_out_load;
    logic            w_in_range;
    logic [CH_W-1:0] w_ch_addr;
    logic            w_rd_en;
    logic [CH_W-1:0] w_rd_addr_hi, w_rd_addr_lo;
    logic [K_W-1:0]  w_rd_k;
    logic            w_wr_en;
    logic [CH_W-1:0] w_wr_addr;
    t_value          w_wr_data;

    // handshake and channel decode
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_in_range  = ({1'b0, i_in.channel} < CHAN_CMP_W'(CHANNELS));
    assign w_ch_addr   = CH_W'(i_in.channel);

    // pair addresses, highest channel first; a get reads its own channel
    always_comb begin
        w_rd_addr_hi = TOP_CH - {w_rd_k, 1'b0};
        w_rd_addr_lo = w_rd_addr_hi - CH_W'(1);
        if (r_state == S_IDLE && i_in.action == ACT_GET) begin
            w_rd_addr_lo = w_ch_addr;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_dc       = r_dc;
        n_pending  = r_pending;
        n_skip     = r_skip;
        n_get_oor  = r_get_oor;
        n_out_kind = r_out_kind;
        n_out_word = r_out_word;
        n_out_rv   = r_out_rv;
        n_out_last = r_out_last;
        w_out_load = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_k     = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_ch_addr;
        w_wr_data  = i_in.value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        ACT_SET: begin
                            w_wr_en = w_in_range;
                        end
                        ACT_GET: begin
                            w_rd_en   = 1'b1;
                            n_get_oor = !w_in_range;
                            n_state   = S_GET;
                        end
                        ACT_SET_ALL: begin
                            n_fill  = i_in.value;
                            n_idx   = '0;
                            n_state = S_SET_ALL;
                        end
                        ACT_UPDATE: begin
                            if (r_pending) begin
                                n_state = S_REFUSE;
                            end else begin
                                w_rd_en   = 1'b1;
                                n_k       = '0;
                                n_pending = 1'b1;
                                n_skip    = 1'b0;
                                n_state   = r_skip ? S_UPD : S_PULSE;
                            end
                        end
                        ACT_DC_ALL: begin
                            n_pending = 1'b0;
                            n_skip    = 1'b1;
                            n_dc      = i_in.value[DC_W-1:0];
                            n_k       = '0;
                            n_state   = S_DC;
                        end
                        ACT_LATCH_DONE: begin
                            n_pending = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GET: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_READ;
                    n_out_word = '0;
                    n_out_rv   = r_get_oor ? '0 : r_rd_lo;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SET_ALL: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = r_fill;
                if (r_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CH_W'(1);
                end
            end
            S_PULSE: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_PULSE;
                    n_out_word = '0;
                    n_out_rv   = '0;
                    n_out_last = 1'b0;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_GRAY;
                    n_out_word = {r_rd_hi, r_rd_lo};
                    n_out_rv   = '0;
                    n_out_last = (r_k == K_LAST);
                    if (r_k == K_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next pair while this word goes out
                        w_rd_en = 1'b1;
                        w_rd_k  = r_k + K_W'(1);
                        n_k     = r_k + K_W'(1);
                    end
                end
            end
            S_DC: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_DC;
                    n_out_word = {r_dc, r_dc, r_dc, r_dc};
                    n_out_rv   = '0;
                    n_out_last = 1'b0;
                    if (r_k == DC_LAST) begin
                        n_state = S_LATCH;
                    end else begin
                        n_k = r_k + K_W'(1);
                    end
                end
            end
            S_LATCH: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_LATCH;
                    n_out_word = '0;
                    n_out_rv   = '0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_REFUSE: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_REFUSED;
                    n_out_word = '0;
                    n_out_rv   = '0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_skip      <= n_skip;
            r_out_valid <= w_out_load || (r_out_valid && !o_out.ready);
            r_k         <= n_k;
            r_idx       <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fill     <= n_fill;
        r_dc       <= n_dc;
        r_get_oor  <= n_get_oor;
        r_out_kind <= n_out_kind;
        r_out_word <= n_out_word;
        r_out_rv   <= n_out_rv;
        r_out_last <= n_out_last;
    end

    // store valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // store write port and registered dual read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_gray[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_hi <= r_vld[w_rd_addr_hi] ? r_gray[w_rd_addr_hi] : '0;
            r_rd_lo <= r_vld[w_rd_addr_lo] ? r_gray[w_rd_addr_lo] : '0;
        end
    end

    // result port
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.word       = r_out_word;
    assign o_out.read_value = r_out_rv;
    assign o_out.last       = r_out_last;

endmodule
